FILE: design/plr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register map of the PCM linear resampler.
// No dependencies; every other file of the block refers to this package by scoped names.

package plr_pkg;

    // Output frame rate. The phase is counted in units of 1/OUTPUT_RATE_HZ of a source frame.
    localparam int OUTPUT_RATE_HZ = 48000;
    localparam int MAX_OUT        = 48;
    localparam int MIN_STEP       = (OUTPUT_RATE_HZ + MAX_OUT - 1) / MAX_OUT;

    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 18;
    localparam int RATE_W    = 18;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int COUNT_W   = $clog2(MAX_OUT);
    localparam int POS_W     = $clog2(OUTPUT_RATE_HZ);
    localparam int SUM_W     = PHASE_W + 1;
    localparam int LANES     = 2;

    // Division by the output rate: 48000 is 375 times 2^7, so the quotient is an arithmetic
    // shift followed by a reciprocal multiply by 1/375 and a single upward correction.
    localparam int     RATE_SHIFT  = 7;
    localparam int     RATE_ODD    = OUTPUT_RATE_HZ >> RATE_SHIFT;
    localparam int     RECIP_SHIFT = 35;
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / RATE_ODD;
    localparam int     RECIP_W     = $clog2(RECIP + 1);

    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int PROD_W  = DIFF_W + POS_W + 1;
    localparam int M_W     = PROD_W - RATE_SHIFT;
    localparam int QPROD_W = M_W + RECIP_W + 1;
    localparam int Q_W     = DIFF_W + 1;
    localparam int R_W     = $clog2(2 * RATE_ODD);
    localparam int GPROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int SAT_MAX = (2 ** (SAMPLE_W - 1)) - 1;
    localparam int SAT_MIN = -(2 ** (SAMPLE_W - 1));

    localparam int PIPE_DEPTH = 6;
    localparam int INFL_W     = $clog2(PIPE_DEPTH + 1);

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic              RST_SIXTEEN = 1'b1;
    localparam logic              RST_STEREO  = 1'b0;
    localparam logic [RATE_W-1:0] RST_RATE    = RATE_W'(22050);
    localparam logic [GAIN_W-1:0] RST_GAIN    = GAIN_W'(32768);

    typedef enum logic [1:0] {
        REG_SIXTEEN = 2'd0,
        REG_STEREO  = 2'd1,
        REG_RATE    = 2'd2,
        REG_GAIN    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        logic              sixteen;
        logic              stereo;
        logic [RATE_W-1:0] rate;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       eob;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } t_result;

endpackage

FILE: design/plr_front.sv
`timescale 1ns / 1ps
// Front end: accepts source frames, converts samples to signed 16-bit, and queues them.
// Depends on plr_pkg.

module plr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  plr_pkg::t_cfg            i_cfg,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [15:0]              i_left_raw,
    input  logic [15:0]              i_right_raw,
    input  logic                     i_end_of_buffer,
    output logic                     o_frame_valid,
    output plr_pkg::t_frame          o_frame,
    input  logic                     i_frame_pop
);

    plr_pkg::t_frame                  r_mem [plr_pkg::FQ_DEPTH];
    logic [plr_pkg::FQ_PTR_W-1:0]     r_wr_ptr;
    logic [plr_pkg::FQ_PTR_W-1:0]     r_rd_ptr;
    logic [plr_pkg::FQ_CNT_W-1:0]     r_count;
    logic                             w_accept;
    logic                             w_take;
    plr_pkg::t_frame                  w_conv;
    logic signed [plr_pkg::SAMPLE_W-1:0] w_left;

    // 8-bit samples are offset binary; flipping the top bit and scaling by 256 centres them.
    function automatic logic signed [plr_pkg::SAMPLE_W-1:0] conv_sample(
        input logic [15:0] raw,
        input logic        sixteen
    );
        logic signed [plr_pkg::SAMPLE_W-1:0] res;
        if (sixteen) begin
            res = $signed(raw);
        end else begin
            res = $signed({raw[7] ^ 1'b1, raw[6:0], 8'h00});
        end
        return res;
    endfunction

    always_comb begin
        w_left      = conv_sample(i_left_raw, i_cfg.sixteen);
        w_conv.left = w_left;
        w_conv.right = i_cfg.stereo ? conv_sample(i_right_raw, i_cfg.sixteen) : w_left;
        w_conv.eob  = i_end_of_buffer;
    end

    assign o_full        = (r_count == plr_pkg::FQ_CNT_W'(plr_pkg::FQ_DEPTH));
    assign o_frame_valid = (r_count != '0);
    assign o_frame       = r_mem[r_rd_ptr];
    assign w_accept      = i_push && !o_full;
    assign w_take        = i_frame_pop && o_frame_valid;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr_ptr] <= w_conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_accept, w_take})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/plr_outq.sv
`timescale 1ns / 1ps
// Result queue between the interpolation pipeline and the output ports.
// Depends on plr_pkg.

module plr_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  plr_pkg::t_result              i_wdata,
    input  logic                          i_pop,
    output logic                          o_empty,
    output plr_pkg::t_result              o_head,
    output logic [plr_pkg::OQ_CNT_W-1:0]  o_used
);

    plr_pkg::t_result              r_mem [plr_pkg::OQ_DEPTH];
    logic [plr_pkg::OQ_PTR_W-1:0]  r_wr_ptr;
    logic [plr_pkg::OQ_PTR_W-1:0]  r_rd_ptr;
    logic [plr_pkg::OQ_CNT_W-1:0]  r_used;
    logic                          w_take;

    assign o_empty = (r_used == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_used  = r_used;
    assign w_take  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, w_take})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

endmodule

FILE: design/plr_back.sv
`timescale 1ns / 1ps
// Back end: phase sequencer and two-lane interpolation and gain pipeline.
// Depends on plr_pkg; writes results into plr_outq under a credit check.

module plr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plr_pkg::t_cfg                 i_cfg,
    input  logic                          i_frame_valid,
    input  plr_pkg::t_frame               i_frame,
    output logic                          o_frame_pop,
    input  logic [plr_pkg::OQ_CNT_W-1:0]  i_out_used,
    output logic                          o_res_valid,
    output plr_pkg::t_result              o_res
);

    // Sequencer state
    plr_pkg::t_back_state                  r_state, n_state;
    logic                                  r_have_prev, n_have_prev;
    logic [plr_pkg::PHASE_W-1:0]           r_phase, n_phase;
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_prev [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   n_prev [plr_pkg::LANES];
    plr_pkg::t_frame                       r_cur, n_cur;
    logic [plr_pkg::COUNT_W-1:0]           r_count, n_count;
    logic [plr_pkg::INFL_W-1:0]            r_inflight;

    logic [plr_pkg::RATE_W-1:0]            w_step;
    logic [plr_pkg::SUM_W-1:0]             w_sum;
    logic                                  w_last;
    logic                                  w_credit;
    logic                                  w_issue;
    logic signed [plr_pkg::SAMPLE_W-1:0]   w_cur [plr_pkg::LANES];

    // Pipeline
    logic [plr_pkg::PIPE_DEPTH-1:0]        r_vld;
    logic [plr_pkg::PIPE_DEPTH-1:0]        r_last;
    logic [plr_pkg::POS_W-1:0]             r_s1_pos;
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_s1_v0 [plr_pkg::LANES];
    logic signed [plr_pkg::DIFF_W-1:0]     r_s1_d  [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_s2_v0 [plr_pkg::LANES];
    logic signed [plr_pkg::PROD_W-1:0]     r_s2_n  [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_s3_v0 [plr_pkg::LANES];
    logic signed [plr_pkg::M_W-1:0]        r_s3_m  [plr_pkg::LANES];
    logic signed [plr_pkg::QPROD_W-1:0]    r_s3_qp [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_s4_v0 [plr_pkg::LANES];
    logic signed [plr_pkg::Q_W-1:0]        r_s4_q  [plr_pkg::LANES];
    logic [plr_pkg::R_W-1:0]               r_s4_r  [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   r_s5_v  [plr_pkg::LANES];
    logic signed [plr_pkg::GPROD_W-1:0]    r_s6_g  [plr_pkg::LANES];

    logic signed [plr_pkg::PROD_W-1:0]     w_n   [plr_pkg::LANES];
    logic signed [plr_pkg::M_W-1:0]        w_m   [plr_pkg::LANES];
    logic signed [plr_pkg::QPROD_W-1:0]    w_qp  [plr_pkg::LANES];
    logic signed [plr_pkg::Q_W-1:0]        w_q   [plr_pkg::LANES];
    logic signed [plr_pkg::M_W-1:0]        w_rem [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   w_v   [plr_pkg::LANES];
    logic signed [plr_pkg::GPROD_W-1:0]    w_g   [plr_pkg::LANES];
    logic signed [plr_pkg::GPROD_W-1:0]    w_gs  [plr_pkg::LANES];
    logic signed [plr_pkg::SAMPLE_W-1:0]   w_sat [plr_pkg::LANES];

    assign w_cur[0] = r_cur.left;
    assign w_cur[1] = r_cur.right;

    always_comb begin
        w_step = (i_cfg.rate < plr_pkg::RATE_W'(plr_pkg::MIN_STEP))
               ? plr_pkg::RATE_W'(plr_pkg::MIN_STEP) : i_cfg.rate;
        w_sum  = {1'b0, r_phase} + {1'b0, w_step};
        w_last = (w_sum >= plr_pkg::SUM_W'(plr_pkg::OUTPUT_RATE_HZ))
              || (r_count == plr_pkg::COUNT_W'(plr_pkg::MAX_OUT - 1));
        // Results still in the pipeline have reserved a place in the result queue.
        w_credit = ({1'b0, i_out_used} + (plr_pkg::OQ_CNT_W + 1)'(r_inflight))
                 < (plr_pkg::OQ_CNT_W + 1)'(plr_pkg::OQ_DEPTH);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plr_pkg::BK_IDLE: begin
                if (i_frame_valid && r_have_prev
                    && (r_phase < plr_pkg::PHASE_W'(plr_pkg::OUTPUT_RATE_HZ))) begin
                    n_state = plr_pkg::BK_RUN;
                end
            end
            plr_pkg::BK_RUN: begin
                if (w_credit && w_last) begin
                    n_state = plr_pkg::BK_IDLE;
                end
            end
            default: n_state = plr_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs and data updates
    always_comb begin
        o_frame_pop = 1'b0;
        w_issue     = 1'b0;
        n_have_prev = r_have_prev;
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_count     = r_count;
        case (r_state)
            plr_pkg::BK_IDLE: begin
                if (i_frame_valid) begin
                    o_frame_pop = 1'b1;
                    if (!r_have_prev) begin
                        // A priming frame is only stored.
                        n_prev[0]   = i_frame.left;
                        n_prev[1]   = i_frame.right;
                        n_phase     = '0;
                        n_have_prev = !i_frame.eob;
                    end else if (r_phase >= plr_pkg::PHASE_W'(plr_pkg::OUTPUT_RATE_HZ)) begin
                        // Source runs faster than the output: this frame yields nothing.
                        n_prev[0] = i_frame.left;
                        n_prev[1] = i_frame.right;
                        n_phase   = r_phase - plr_pkg::PHASE_W'(plr_pkg::OUTPUT_RATE_HZ);
                        if (i_frame.eob) begin
                            n_have_prev = 1'b0;
                            n_phase     = '0;
                        end
                    end else begin
                        n_cur   = i_frame;
                        n_count = '0;
                    end
                end
            end
            plr_pkg::BK_RUN: begin
                if (w_credit) begin
                    w_issue = 1'b1;
                    n_count = r_count + 1'b1;
                    if (w_last) begin
                        n_prev[0] = r_cur.left;
                        n_prev[1] = r_cur.right;
                        n_phase   = plr_pkg::PHASE_W'(w_sum
                                    - plr_pkg::SUM_W'(plr_pkg::OUTPUT_RATE_HZ));
                        if (r_cur.eob) begin
                            n_have_prev = 1'b0;
                            n_phase     = '0;
                        end
                    end else begin
                        n_phase = w_sum[plr_pkg::PHASE_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plr_pkg::BK_IDLE;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_prev[0]   <= '0;
            r_prev[1]   <= '0;
            r_count     <= '0;
            r_vld       <= '0;
            r_inflight  <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_vld       <= {r_vld[plr_pkg::PIPE_DEPTH-2:0], w_issue};
            r_inflight  <= r_inflight + plr_pkg::INFL_W'(w_issue)
                         - plr_pkg::INFL_W'(r_vld[plr_pkg::PIPE_DEPTH-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // Datapath: d*p, divide by the output rate, add to v0, apply gain, saturate.
    always_comb begin
        for (int k = 0; k < plr_pkg::LANES; k++) begin
            w_n[k]   = r_s1_d[k] * $signed({1'b0, r_s1_pos});
            w_m[k]   = plr_pkg::M_W'(r_s2_n[k] >>> plr_pkg::RATE_SHIFT);
            w_qp[k]  = w_m[k] * $signed({1'b0, plr_pkg::RECIP_W'(plr_pkg::RECIP)});
            w_q[k]   = plr_pkg::Q_W'(r_s3_qp[k] >>> plr_pkg::RECIP_SHIFT);
            w_rem[k] = r_s3_m[k] - (plr_pkg::M_W'(w_q[k])
                     * $signed(plr_pkg::M_W'(plr_pkg::RATE_ODD)));
            // The reciprocal estimate is at most one below the floored quotient.
            w_v[k]   = plr_pkg::SAMPLE_W'(plr_pkg::Q_W'(r_s4_v0[k]) + r_s4_q[k]
                     + plr_pkg::Q_W'(r_s4_r[k] >= plr_pkg::R_W'(plr_pkg::RATE_ODD)));
            w_g[k]   = r_s5_v[k] * $signed({1'b0, i_cfg.gain});
            w_gs[k]  = r_s6_g[k] >>> plr_pkg::GAIN_FRAC;
            if (w_gs[k] > $signed(plr_pkg::GPROD_W'(plr_pkg::SAT_MAX))) begin
                w_sat[k] = plr_pkg::SAMPLE_W'(plr_pkg::SAT_MAX);
            end else if (w_gs[k] < $signed(plr_pkg::GPROD_W'(plr_pkg::SAT_MIN))) begin
                w_sat[k] = plr_pkg::SAMPLE_W'(plr_pkg::SAT_MIN);
            end else begin
                w_sat[k] = plr_pkg::SAMPLE_W'(w_gs[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= {r_last[plr_pkg::PIPE_DEPTH-2:0], w_last};
        r_s1_pos <= r_phase[plr_pkg::POS_W-1:0];
        for (int k = 0; k < plr_pkg::LANES; k++) begin
            r_s1_v0[k] <= r_prev[k];
            r_s1_d[k]  <= plr_pkg::DIFF_W'(w_cur[k]) - plr_pkg::DIFF_W'(r_prev[k]);
            r_s2_v0[k] <= r_s1_v0[k];
            r_s2_n[k]  <= w_n[k];
            r_s3_v0[k] <= r_s2_v0[k];
            r_s3_m[k]  <= w_m[k];
            r_s3_qp[k] <= w_qp[k];
            r_s4_v0[k] <= r_s3_v0[k];
            r_s4_q[k]  <= w_q[k];
            r_s4_r[k]  <= plr_pkg::R_W'(w_rem[k]);
            r_s5_v[k]  <= w_v[k];
            r_s6_g[k]  <= w_g[k];
        end
    end

    assign o_res_valid = r_vld[plr_pkg::PIPE_DEPTH-1];
    assign o_res.left  = w_sat[0];
    assign o_res.right = w_sat[1];
    assign o_res.last  = r_last[plr_pkg::PIPE_DEPTH-1];

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_last) |=> (r_state == plr_pkg::BK_IDLE))
        else $error("sequencer kept running after the last result of a frame");

    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plr_pkg::BK_RUN)
            |-> (r_phase < plr_pkg::PHASE_W'(plr_pkg::OUTPUT_RATE_HZ)))
        else $error("phase reached a full frame while results were being issued");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        plr_pkg::INFL_W'($countones(r_vld)) == r_inflight)
        else $error("in-flight count disagrees with the pipeline valid bits");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame_pop && r_have_prev
            && (r_phase < plr_pkg::PHASE_W'(plr_pkg::OUTPUT_RATE_HZ)))
            |=> ((r_state == plr_pkg::BK_RUN) && (r_count == '0)))
        else $error("a frame with results did not start a run");

endmodule

FILE: design/pcm_linear_resampler_top.sv
`timescale 1ns / 1ps
// Top level of the PCM linear resampler: configuration registers and the three stages.
// Depends on plr_pkg, plr_front, plr_back and plr_outq.
//
//   Channel   Ports                                            Handshake
//   -------   ----------------------------------------------   ----------------------
//   frames    i_left_raw, i_right_raw, i_end_of_buffer         push / full
//   results   o_left_out, o_right_out, o_last_of_run           empty / pop
//   config    psel, penable, pwrite, paddr, pwdata, prdata     APB, pready tied high
//
// A frame that causes results is popped in the idle state, and the run state then issues one
// result per cycle while the result queue has room; a frame that only primes or is skipped is
// popped, yielding none. Results pass the six-stage interpolation pipeline to the result queue.
// Results issue only while the eight-entry result queue has room for all results in flight,
// so a stalled consumer backs up into the four-entry frame queue and then raises full.
// Reset is synchronous; registers return to their defaults and both queues are emptied.

module pcm_linear_resampler_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [15:0]                          i_left_raw,
    input  logic [15:0]                          i_right_raw,
    input  logic                                 i_end_of_buffer,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [15:0]                   o_left_out,
    output logic signed [15:0]                   o_right_out,
    output logic                                 o_last_of_run,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [plr_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [plr_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    logic                          r_sixteen;
    logic                          r_stereo;
    logic [plr_pkg::RATE_W-1:0]    r_rate;
    logic [plr_pkg::GAIN_W-1:0]    r_gain;
    plr_pkg::t_cfg                 w_cfg;
    plr_pkg::t_reg_idx             w_idx;
    logic                          w_wr;

    logic                          w_frame_valid;
    plr_pkg::t_frame               w_frame;
    logic                          w_frame_pop;
    logic                          w_res_valid;
    plr_pkg::t_result              w_res;
    plr_pkg::t_result              w_head;
    logic [plr_pkg::OQ_CNT_W-1:0]  w_used;

    assign pready = 1'b1;
    assign w_idx  = plr_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sixteen <= plr_pkg::RST_SIXTEEN;
            r_stereo  <= plr_pkg::RST_STEREO;
            r_rate    <= plr_pkg::RST_RATE;
            r_gain    <= plr_pkg::RST_GAIN;
        end else if (w_wr) begin
            case (w_idx)
                plr_pkg::REG_SIXTEEN: r_sixteen <= pwdata[0];
                plr_pkg::REG_STEREO:  r_stereo  <= pwdata[0];
                plr_pkg::REG_RATE:    r_rate    <= pwdata[plr_pkg::RATE_W-1:0];
                plr_pkg::REG_GAIN:    r_gain    <= pwdata[plr_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            plr_pkg::REG_SIXTEEN: prdata = plr_pkg::APB_DATA_W'(r_sixteen);
            plr_pkg::REG_STEREO:  prdata = plr_pkg::APB_DATA_W'(r_stereo);
            plr_pkg::REG_RATE:    prdata = plr_pkg::APB_DATA_W'(r_rate);
            plr_pkg::REG_GAIN:    prdata = plr_pkg::APB_DATA_W'(r_gain);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.sixteen = r_sixteen;
        w_cfg.stereo  = r_stereo;
        w_cfg.rate    = r_rate;
        w_cfg.gain    = r_gain;
    end

    plr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_left_raw      (i_left_raw),
        .i_right_raw     (i_right_raw),
        .i_end_of_buffer (i_end_of_buffer),
        .o_frame_valid   (w_frame_valid),
        .o_frame         (w_frame),
        .i_frame_pop     (w_frame_pop)
    );

    plr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_frame_valid (w_frame_valid),
        .i_frame       (w_frame),
        .o_frame_pop   (w_frame_pop),
        .i_out_used    (w_used),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    plr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_wdata (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (w_head),
        .o_used  (w_used)
    );

    assign o_left_out    = w_head.left;
    assign o_right_out   = w_head.right;
    assign o_last_of_run = w_head.last;

endmodule
